### rtl/pap_pkg.sv
`timescale 1ns / 1ps

package pap_pkg;

  // Field and datapath widths
  localparam int ANGLE_W    = 15;
  localparam int AZ_W       = 16;
  localparam int CH_W       = 3;
  localparam int CNT_W      = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int DIST_W     = 16;
  localparam int QUO_W      = 16;
  localparam int WGT_W      = 17;
  localparam int FRAC_W     = 15;

  // Divider split: quotient bits resolved per pipeline stage
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = QUO_W / DIV_STAGES;

  // Angle constants in 1/64 degree
  localparam logic [ANGLE_W-1:0] FULL_TURN    = 15'd23040;
  localparam logic [ANGLE_W-1:0] ABSENT_ANGLE = 15'd23040;
  localparam logic [AZ_W-1:0]    TWO_TURNS    = 16'd46080;

  // Unity weight in Q1.15
  localparam logic [WGT_W-1:0] ONE_Q15 = 17'd32768;

  // Active speaker count codes
  localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_PAIR = 2'd2;

  typedef logic [ANGLE_W-1:0] angle_t;
  typedef logic [CH_W-1:0]    chan_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    chan_t            l_ch;
    chan_t            r_ch;
  } pan_ctrl_t;

endpackage

### rtl/pap_cfg.sv
`timescale 1ns / 1ps

module pap_cfg import pap_pkg::*; #(
  parameter int NUM_SPEAKERS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_valid,
  input  logic [CFG_IDX_W-1:0]                     cfg_index,
  input  angle_t                                   cfg_data,
  output logic [NUM_SPEAKERS-1:0]                  present,
  output angle_t [NUM_SPEAKERS-1:0]                angle,
  output logic [NUM_SPEAKERS-1:0][NUM_SPEAKERS-1:0] ahead
);

  angle_t [NUM_SPEAKERS-1:0] angle_r;

  // Store speaker angles; writes to unused channels are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SPEAKERS; i++) begin
        angle_r[i] <= ABSENT_ANGLE;
      end
    end else begin
      for (int i = 0; i < NUM_SPEAKERS; i++) begin
        if (cfg_valid && (cfg_index == CFG_IDX_W'(i))) begin
          angle_r[i] <= cfg_data;
        end
      end
    end
  end

  // Reduce angles into one turn and flag present speakers
  always_comb begin
    for (int i = 0; i < NUM_SPEAKERS; i++) begin
      present[i] = (angle_r[i] != ABSENT_ANGLE);
      angle[i]   = (angle_r[i] > FULL_TURN) ? (angle_r[i] - FULL_TURN) : angle_r[i];
    end
  end

  // Order relation: ahead[i][j] when speaker i sorts ahead of speaker j
  always_comb begin
    for (int i = 0; i < NUM_SPEAKERS; i++) begin
      for (int j = 0; j < NUM_SPEAKERS; j++) begin
        if (i == j) begin
          ahead[i][j] = 1'b0;
        end else begin
          ahead[i][j] = present[i] && present[j] &&
                        ((angle[i] < angle[j]) || ((angle[i] == angle[j]) && (i < j)));
        end
      end
    end
  end

endmodule

### rtl/pap_select.sv
`timescale 1ns / 1ps

module pap_select import pap_pkg::*; #(
  parameter int NUM_SPEAKERS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     adv,
  input  logic                                     in_valid,
  input  logic signed [SAMPLE_BITS-1:0]            in_sample,
  input  logic [AZ_W-1:0]                          in_azimuth,
  input  logic [NUM_SPEAKERS-1:0]                  present,
  input  angle_t [NUM_SPEAKERS-1:0]                angle,
  input  logic [NUM_SPEAKERS-1:0][NUM_SPEAKERS-1:0] ahead,
  output logic                                     out_valid,
  output logic signed [SAMPLE_BITS-1:0]            out_sample,
  output logic [DIST_W-1:0]                        out_dleft,
  output logic [DIST_W-1:0]                        out_sum,
  output pan_ctrl_t                                out_ctrl
);

  localparam int PC_W = $clog2(NUM_SPEAKERS + 1);

  function automatic angle_t abs_diff(input angle_t a, input angle_t b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // ---------------- stage 1: azimuth wrap and candidate mask
  logic [AZ_W-1:0]                 az_mod;
  angle_t                          az1_nxt;
  logic [NUM_SPEAKERS-1:0]         cand1_nxt;

  logic                            v1_r;
  logic signed [SAMPLE_BITS-1:0]   sample1_r;
  angle_t                          az1_r;
  logic [NUM_SPEAKERS-1:0]         cand1_r;

  always_comb begin
    if (in_azimuth >= TWO_TURNS) begin
      az_mod = in_azimuth - TWO_TURNS;
    end else if (in_azimuth >= AZ_W'(FULL_TURN)) begin
      az_mod = in_azimuth - AZ_W'(FULL_TURN);
    end else begin
      az_mod = in_azimuth;
    end
    az1_nxt = az_mod[ANGLE_W-1:0];
    for (int i = 0; i < NUM_SPEAKERS; i++) begin
      cand1_nxt[i] = present[i] && (angle[i] >= az1_nxt);
    end
  end

  // ---------------- stage 2: pick right speaker and count
  logic [NUM_SPEAKERS-1:0]         base2;
  logic [NUM_SPEAKERS-1:0]         r2_nxt;
  logic [NUM_SPEAKERS-1:0]         first2;
  logic                            rf2_nxt;
  logic [PC_W-1:0]                 pc2;
  logic [CNT_W-1:0]                cnt2_nxt;

  logic                            v2_r;
  logic signed [SAMPLE_BITS-1:0]   sample2_r;
  angle_t                          az2_r;
  logic [NUM_SPEAKERS-1:0]         r2_r;
  logic                            rf2_r;
  logic [CNT_W-1:0]                cnt2_r;

  always_comb begin
    logic blk;
    logic first_blk;
    base2 = (|cand1_r) ? cand1_r : present;
    for (int i = 0; i < NUM_SPEAKERS; i++) begin
      blk       = 1'b0;
      first_blk = 1'b0;
      for (int j = 0; j < NUM_SPEAKERS; j++) begin
        blk       = blk | (base2[j] & ahead[j][i]);
        first_blk = first_blk | ahead[j][i];
      end
      r2_nxt[i] = base2[i] & ~blk;
      first2[i] = present[i] & ~first_blk;
    end
    rf2_nxt = |(r2_nxt & first2);

    pc2 = '0;
    for (int i = 0; i < NUM_SPEAKERS; i++) begin
      pc2 = pc2 + PC_W'(present[i]);
    end
    if (pc2 == '0) begin
      cnt2_nxt = CNT_NONE;
    end else if (pc2 == PC_W'(1)) begin
      cnt2_nxt = CNT_ONE;
    end else begin
      cnt2_nxt = CNT_PAIR;
    end
  end

  // ---------------- stage 3: pick left speaker, fetch both angles
  logic [NUM_SPEAKERS-1:0]         bef_r3;
  logic [NUM_SPEAKERS-1:0]         last3;
  logic [NUM_SPEAKERS-1:0]         pred3;
  logic [NUM_SPEAKERS-1:0]         l3;
  angle_t                          al3_nxt;
  angle_t                          ar3_nxt;
  pan_ctrl_t                       ctrl3_nxt;

  logic                            v3_r;
  logic signed [SAMPLE_BITS-1:0]   sample3_r;
  angle_t                          az3_r;
  angle_t                          al3_r;
  angle_t                          ar3_r;
  logic                            rf3_r;
  pan_ctrl_t                       ctrl3_r;

  always_comb begin
    logic last_blk;
    logic link_blk;
    for (int i = 0; i < NUM_SPEAKERS; i++) begin
      bef_r3[i] = |(ahead[i] & r2_r);
    end
    for (int i = 0; i < NUM_SPEAKERS; i++) begin
      last_blk = 1'b0;
      link_blk = 1'b0;
      for (int j = 0; j < NUM_SPEAKERS; j++) begin
        last_blk = last_blk | ahead[i][j];
        link_blk = link_blk | (ahead[i][j] & bef_r3[j]);
      end
      last3[i] = present[i] & ~last_blk;
      pred3[i] = bef_r3[i] & ~link_blk;
    end
    l3 = rf2_r ? last3 : pred3;

    al3_nxt         = '0;
    ar3_nxt         = '0;
    ctrl3_nxt.count = cnt2_r;
    ctrl3_nxt.l_ch  = '0;
    ctrl3_nxt.r_ch  = '0;
    for (int i = 0; i < NUM_SPEAKERS; i++) begin
      al3_nxt        = al3_nxt | (angle[i] & {ANGLE_W{l3[i]}});
      ar3_nxt        = ar3_nxt | (angle[i] & {ANGLE_W{r2_r[i]}});
      ctrl3_nxt.l_ch = ctrl3_nxt.l_ch | (l3[i] ? CH_W'(i) : '0);
      ctrl3_nxt.r_ch = ctrl3_nxt.r_ch | (r2_r[i] ? CH_W'(i) : '0);
    end
  end

  // ---------------- stage 4: angular distances with wrap
  logic [DIST_W-1:0]               d1_nxt;
  logic [DIST_W-1:0]               d2_nxt;

  logic                            v4_r;
  logic signed [SAMPLE_BITS-1:0]   sample4_r;
  logic [DIST_W-1:0]               d1_r;
  logic [DIST_W-1:0]               sum4_r;
  pan_ctrl_t                       ctrl4_r;

  always_comb begin
    if (rf3_r) begin
      if (az3_r >= al3_r) begin
        d1_nxt = DIST_W'(az3_r - al3_r);
        d2_nxt = DIST_W'(FULL_TURN) - DIST_W'(az3_r) + DIST_W'(ar3_r);
      end else begin
        d1_nxt = DIST_W'(FULL_TURN) - DIST_W'(al3_r) + DIST_W'(az3_r);
        d2_nxt = DIST_W'(abs_diff(ar3_r, az3_r));
      end
    end else begin
      d1_nxt = DIST_W'(abs_diff(al3_r, az3_r));
      d2_nxt = DIST_W'(abs_diff(ar3_r, az3_r));
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      sample1_r <= in_sample;
      az1_r     <= az1_nxt;
      cand1_r   <= cand1_nxt;

      sample2_r <= sample1_r;
      az2_r     <= az1_r;
      r2_r      <= r2_nxt;
      rf2_r     <= rf2_nxt;
      cnt2_r    <= cnt2_nxt;

      sample3_r <= sample2_r;
      az3_r     <= az2_r;
      al3_r     <= al3_nxt;
      ar3_r     <= ar3_nxt;
      rf3_r     <= rf2_r;
      ctrl3_r   <= ctrl3_nxt;

      sample4_r <= sample3_r;
      d1_r      <= d1_nxt;
      sum4_r    <= d1_nxt + d2_nxt;
      ctrl4_r   <= ctrl3_r;
    end
  end

  assign out_valid  = v4_r;
  assign out_sample = sample4_r;
  assign out_dleft  = d1_r;
  assign out_sum    = sum4_r;
  assign out_ctrl   = ctrl4_r;

endmodule

### rtl/pap_div.sv
`timescale 1ns / 1ps

module pap_div import pap_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [DIST_W-1:0]             in_dleft,
  input  logic [DIST_W-1:0]             in_sum,
  input  pan_ctrl_t                     in_ctrl,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic [QUO_W-1:0]              out_quo,
  output logic                          out_rem_nz,
  output logic                          out_sum_zero,
  output pan_ctrl_t                     out_ctrl
);

  // Restoring division of dleft * 2^15 by sum, DIV_STEPS quotient bits per stage
  logic                          v_r      [DIV_STAGES];
  logic signed [SAMPLE_BITS-1:0] sample_r [DIV_STAGES];
  logic [DIST_W-1:0]             rem_r    [DIV_STAGES];
  logic [DIST_W-1:0]             sum_r    [DIV_STAGES];
  logic [QUO_W-1:0]              quo_r    [DIV_STAGES];
  pan_ctrl_t                     ctrl_r   [DIV_STAGES];

  logic [DIST_W-1:0]             rem_src  [DIV_STAGES];
  logic [DIST_W-1:0]             sum_src  [DIV_STAGES];
  logic [QUO_W-1:0]              quo_src  [DIV_STAGES];
  logic [DIST_W-1:0]             rem_nxt  [DIV_STAGES];
  logic [QUO_W-1:0]              quo_nxt  [DIV_STAGES];

  // Line up each stage's source operands
  always_comb begin
    rem_src[0] = in_dleft;
    sum_src[0] = in_sum;
    quo_src[0] = '0;
    for (int k = 1; k < DIV_STAGES; k++) begin
      rem_src[k] = rem_r[k-1];
      sum_src[k] = sum_r[k-1];
      quo_src[k] = quo_r[k-1];
    end
  end

  // Resolve quotient bits; the leading bit compares without a shift
  always_comb begin
    logic [DIST_W:0] part;
    for (int k = 0; k < DIV_STAGES; k++) begin
      rem_nxt[k] = rem_src[k];
      quo_nxt[k] = quo_src[k];
      for (int j = 0; j < DIV_STEPS; j++) begin
        if ((k == 0) && (j == 0)) begin
          part = {1'b0, rem_nxt[k]};
        end else begin
          part = {rem_nxt[k], 1'b0};
        end
        if (part >= {1'b0, sum_src[k]}) begin
          part       = part - {1'b0, sum_src[k]};
          quo_nxt[k] = {quo_nxt[k][QUO_W-2:0], 1'b1};
        end else begin
          quo_nxt[k] = {quo_nxt[k][QUO_W-2:0], 1'b0};
        end
        rem_nxt[k] = part[DIST_W-1:0];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      sample_r[0] <= in_sample;
      ctrl_r[0]   <= in_ctrl;
      for (int k = 1; k < DIV_STAGES; k++) begin
        sample_r[k] <= sample_r[k-1];
        ctrl_r[k]   <= ctrl_r[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_r[k] <= rem_nxt[k];
        sum_r[k] <= sum_src[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign out_valid    = v_r[DIV_STAGES-1];
  assign out_sample   = sample_r[DIV_STAGES-1];
  assign out_quo      = quo_r[DIV_STAGES-1];
  assign out_rem_nz   = |rem_r[DIV_STAGES-1];
  assign out_sum_zero = (sum_r[DIV_STAGES-1] == '0);
  assign out_ctrl     = ctrl_r[DIV_STAGES-1];

endmodule

### rtl/pap_scale.sv
`timescale 1ns / 1ps

module pap_scale import pap_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [QUO_W-1:0]              in_quo,
  input  logic                          in_rem_nz,
  input  logic                          in_sum_zero,
  input  pan_ctrl_t                     in_ctrl,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_first_sample,
  output logic signed [SAMPLE_BITS-1:0] out_second_sample,
  output pan_ctrl_t                     out_ctrl
);

  localparam int PROD_W = SAMPLE_BITS + WGT_W + 1;

  // ---------------- stage A: weights from quotient, special cases
  logic [WGT_W-1:0]              w1_nxt;
  logic [WGT_W-1:0]              w2_nxt;
  pan_ctrl_t                     ctrla_nxt;

  logic                          va_r;
  logic signed [SAMPLE_BITS-1:0] samplea_r;
  logic [WGT_W-1:0]              w1_r;
  logic [WGT_W-1:0]              w2_r;
  pan_ctrl_t                     ctrla_r;

  always_comb begin
    ctrla_nxt = in_ctrl;
    case (in_ctrl.count)
      CNT_PAIR: begin
        if (in_sum_zero) begin
          w1_nxt = ONE_Q15;
          w2_nxt = '0;
        end else begin
          // left weight is the complement of the right one, less one on a remainder
          w2_nxt = {1'b0, in_quo};
          w1_nxt = ONE_Q15 - {1'b0, in_quo} - WGT_W'(in_rem_nz);
        end
      end
      CNT_ONE: begin
        w1_nxt         = ONE_Q15;
        w2_nxt         = '0;
        ctrla_nxt.r_ch = '0;
      end
      default: begin
        w1_nxt         = '0;
        w2_nxt         = '0;
        ctrla_nxt.l_ch = '0;
        ctrla_nxt.r_ch = '0;
      end
    endcase
  end

  // ---------------- stage B: weighted products
  logic signed [PROD_W-1:0]      p1_nxt;
  logic signed [PROD_W-1:0]      p2_nxt;

  logic                          vb_r;
  logic signed [PROD_W-1:0]      p1_r;
  logic signed [PROD_W-1:0]      p2_r;
  pan_ctrl_t                     ctrlb_r;

  assign p1_nxt = PROD_W'(samplea_r) * PROD_W'($signed({1'b0, w1_r}));
  assign p2_nxt = PROD_W'(samplea_r) * PROD_W'($signed({1'b0, w2_r}));

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      samplea_r <= in_sample;
      w1_r      <= w1_nxt;
      w2_r      <= w2_nxt;
      ctrla_r   <= ctrla_nxt;
      p1_r      <= p1_nxt;
      p2_r      <= p2_nxt;
      ctrlb_r   <= ctrla_r;
    end
  end

  // Floor by dropping the fraction bits of the signed product
  assign out_valid         = vb_r;
  assign out_first_sample  = p1_r[FRAC_W +: SAMPLE_BITS];
  assign out_second_sample = p2_r[FRAC_W +: SAMPLE_BITS];
  assign out_ctrl          = ctrlb_r;

endmodule

### rtl/pairwise_amplitude_panner_top.sv
// The select, divider and scale pipelines run on a shared advance enable.
// Throughput: one transaction per cycle while in_stall is low.
// A one-entry skid buffer behind the output register raises in_stall only while it is full.
// Reset (rst_n, synchronous, active low) clears all valid bits and marks every speaker absent.
`timescale 1ns / 1ps

module pairwise_amplitude_panner_top import pap_pkg::*; #(
  parameter int NUM_SPEAKERS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  angle_t                        cfg_data,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic [AZ_W-1:0]               in_azimuth,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [CNT_W-1:0]              out_active_count,
  output chan_t                         out_first_channel,
  output logic signed [SAMPLE_BITS-1:0] out_first_sample,
  output chan_t                         out_second_channel,
  output logic signed [SAMPLE_BITS-1:0] out_second_sample
);

  logic [NUM_SPEAKERS-1:0]                  present;
  angle_t [NUM_SPEAKERS-1:0]                angle;
  logic [NUM_SPEAKERS-1:0][NUM_SPEAKERS-1:0] ahead;

  logic                          adv;

  logic                          sel_valid;
  logic signed [SAMPLE_BITS-1:0] sel_sample;
  logic [DIST_W-1:0]             sel_dleft;
  logic [DIST_W-1:0]             sel_sum;
  pan_ctrl_t                     sel_ctrl;

  logic                          div_valid;
  logic signed [SAMPLE_BITS-1:0] div_sample;
  logic [QUO_W-1:0]              div_quo;
  logic                          div_rem_nz;
  logic                          div_sum_zero;
  pan_ctrl_t                     div_ctrl;

  logic                          sc_valid;
  logic signed [SAMPLE_BITS-1:0] sc_first;
  logic signed [SAMPLE_BITS-1:0] sc_second;
  pan_ctrl_t                     sc_ctrl;

  logic                          out_valid_r;
  pan_ctrl_t                     out_ctrl_r;
  logic signed [SAMPLE_BITS-1:0] out_first_r;
  logic signed [SAMPLE_BITS-1:0] out_second_r;

  logic                          skid_valid_r;
  pan_ctrl_t                     skid_ctrl_r;
  logic signed [SAMPLE_BITS-1:0] skid_first_r;
  logic signed [SAMPLE_BITS-1:0] skid_second_r;

  logic                          take;
  logic                          out_free;

  // Pipeline advances whenever the skid entry is empty
  assign adv       = ~skid_valid_r;
  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;

  pap_cfg #(
    .NUM_SPEAKERS (NUM_SPEAKERS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .present   (present),
    .angle     (angle),
    .ahead     (ahead)
  );

  pap_select #(
    .NUM_SPEAKERS (NUM_SPEAKERS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_select (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_valid),
    .in_sample  (in_sample_in),
    .in_azimuth (in_azimuth),
    .present    (present),
    .angle      (angle),
    .ahead      (ahead),
    .out_valid  (sel_valid),
    .out_sample (sel_sample),
    .out_dleft  (sel_dleft),
    .out_sum    (sel_sum),
    .out_ctrl   (sel_ctrl)
  );

  pap_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (sel_valid),
    .in_sample    (sel_sample),
    .in_dleft     (sel_dleft),
    .in_sum       (sel_sum),
    .in_ctrl      (sel_ctrl),
    .out_valid    (div_valid),
    .out_sample   (div_sample),
    .out_quo      (div_quo),
    .out_rem_nz   (div_rem_nz),
    .out_sum_zero (div_sum_zero),
    .out_ctrl     (div_ctrl)
  );

  pap_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv               (adv),
    .in_valid          (div_valid),
    .in_sample         (div_sample),
    .in_quo            (div_quo),
    .in_rem_nz         (div_rem_nz),
    .in_sum_zero       (div_sum_zero),
    .in_ctrl           (div_ctrl),
    .out_valid         (sc_valid),
    .out_first_sample  (sc_first),
    .out_second_sample (sc_second),
    .out_ctrl          (sc_ctrl)
  );

  assign take     = adv & sc_valid;
  assign out_free = ~out_valid_r | ~out_stall;

  // Output register and skid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r | take;
      skid_valid_r <= 1'b0;
    end else if (take) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Move transactions into the output register or park them in the skid entry
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_ctrl_r   <= skid_ctrl_r;
        out_first_r  <= skid_first_r;
        out_second_r <= skid_second_r;
      end else if (take) begin
        out_ctrl_r   <= sc_ctrl;
        out_first_r  <= sc_first;
        out_second_r <= sc_second;
      end
    end else if (take) begin
      skid_ctrl_r   <= sc_ctrl;
      skid_first_r  <= sc_first;
      skid_second_r <= sc_second;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_active_count   = out_ctrl_r.count;
  assign out_first_channel  = out_ctrl_r.l_ch;
  assign out_first_sample   = out_first_r;
  assign out_second_channel = out_ctrl_r.r_ch;
  assign out_second_sample  = out_second_r;

endmodule
